>>> rtl/kbc_pkg.sv
// shared constants, types and helpers for the keypress and bigram counter
package kbc_pkg;

    // key matrix geometry
    localparam int ROWS = 8;
    localparam int COLS = 16;
    localparam int KEYS = 128;

    // store sizes and address widths
    localparam int KEY_DEPTH  = ROWS * COLS;
    localparam int KEY_AW     = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int PAIR_DEPTH = KEYS * KEYS;
    localparam int PAIR_AW    = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
    localparam int PREV_W     = (KEYS > 1) ? $clog2(KEYS) : 1;

    // saturation limits
    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
    localparam logic [15:0] MAX16 = 16'hFFFF;

    // operation codes
    localparam logic [2:0] OP_PRESS       = 3'd0;
    localparam logic [2:0] OP_READ_KEY    = 3'd1;
    localparam logic [2:0] OP_READ_PAIR   = 3'd2;
    localparam logic [2:0] OP_CLEAR_KEYS  = 3'd3;
    localparam logic [2:0] OP_CLEAR_PAIRS = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic exec;
        logic sweep;
    } kbc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
        logic op_pair_clear;
        logic sweep_last;
    } kbc_status_t;

    // saturating 32-bit increment
    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        return (v == MAX32) ? v : v + 32'd1;
    endfunction

endpackage

>>> rtl/keypress_and_bigram_counter_core.sv
// top level of the keypress and bigram counter
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    operation, row, col, first_key, second_key
//  m_       out        m_valid / m_ready    key_count, pair_count, totals, peaks, accepted
//  cfg_     in         cfg_wr_en            cfg_wr_data (stats_enable)
//
// the accept edge reads both stores, the next cycle writes back and loads the
// output register; the stores' single ports set this split
// a pair clear is followed by a clearing pass of the pair store, one entry a
// cycle (16384 entries), during which no item is accepted
// the same pass runs after reset; configuration writes are taken at any time
// a result waiting in the output register lets the next item in once taken
module keypress_and_bigram_counter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [7:0]  s_row,
    input  logic [7:0]  s_col,
    input  logic [7:0]  s_first_key,
    input  logic [7:0]  s_second_key,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_key_count,
    output logic [15:0] m_pair_count,
    output logic [31:0] m_press_total,
    output logic [31:0] m_pair_total,
    output logic [31:0] m_largest_key_count,
    output logic [15:0] m_largest_pair_count,
    output logic        m_accepted
);
    import kbc_pkg::*;

    kbc_cmd_t    cmd;
    kbc_status_t status;

    // sequencing
    kbc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // stores and arithmetic
    kbc_datapath u_datapath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .status               (status),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_data          (cfg_wr_data),
        .s_operation          (s_operation),
        .s_row                (s_row),
        .s_col                (s_col),
        .s_first_key          (s_first_key),
        .s_second_key         (s_second_key),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_key_count          (m_key_count),
        .m_pair_count         (m_pair_count),
        .m_press_total        (m_press_total),
        .m_pair_total         (m_pair_total),
        .m_largest_key_count  (m_largest_key_count),
        .m_largest_pair_count (m_largest_pair_count),
        .m_accepted           (m_accepted)
    );

endmodule

>>> rtl/kbc_ctrl.sv
// controller state machine for the keypress and bigram counter
module kbc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  kbc_pkg::kbc_status_t status,
    output kbc_pkg::kbc_cmd_t    cmd
);
    import kbc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP
    } state_t;

    state_t state_reg;

    // handshake and commands
    assign s_ready    = (state_reg == ST_IDLE) && status.out_free;
    assign cmd.accept = s_ready && s_valid;
    assign cmd.exec   = (state_reg == ST_EXEC);
    assign cmd.sweep  = (state_reg == ST_SWEEP);

    // state register, clearing pass of the pair store first after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SWEEP;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && status.out_free) state_reg <= ST_EXEC;
                end
                ST_EXEC: begin
                    state_reg <= status.op_pair_clear ? ST_SWEEP : ST_IDLE;
                end
                ST_SWEEP: begin
                    if (status.sweep_last) state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/kbc_datapath.sv
// stores, counters and result register of the keypress and bigram counter
module kbc_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  kbc_pkg::kbc_cmd_t    cmd,
    output kbc_pkg::kbc_status_t status,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  logic [2:0]           s_operation,
    input  logic [7:0]           s_row,
    input  logic [7:0]           s_col,
    input  logic [7:0]           s_first_key,
    input  logic [7:0]           s_second_key,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [31:0]          m_key_count,
    output logic [15:0]          m_pair_count,
    output logic [31:0]          m_press_total,
    output logic [31:0]          m_pair_total,
    output logic [31:0]          m_largest_key_count,
    output logic [15:0]          m_largest_pair_count,
    output logic                 m_accepted
);
    import kbc_pkg::*;

    // memories
    logic [31:0] key_mem  [KEY_DEPTH];
    logic [15:0] pair_mem [PAIR_DEPTH];

    // control and architectural state
    logic [KEY_DEPTH-1:0] key_valid_reg;
    logic                 stats_enable_reg;
    logic [31:0]          presses_sum_reg, presses_sum_next;
    logic [31:0]          pairs_sum_reg, pairs_sum_next;
    logic [31:0]          key_peak_reg, key_peak_next;
    logic [15:0]          pair_peak_reg, pair_peak_next;
    logic [PREV_W-1:0]    prev_key_reg;
    logic                 prev_valid_reg;
    logic [PAIR_AW-1:0]   sweep_reg;
    logic                 m_valid_reg;

    // item registers captured on accept
    logic [2:0]         op_reg;
    logic               in_range_reg;
    logic               idx_low_reg;
    logic               pair_ok_reg;
    logic [KEY_AW-1:0]  key_addr_reg;
    logic [PAIR_AW-1:0] pair_addr_reg;
    logic [31:0]        key_rd_reg;
    logic               key_hit_reg;
    logic [15:0]        pair_rd_reg;

    // result registers
    logic [31:0] kc_reg, kc_next;
    logic [15:0] pc_reg, pc_next;
    logic        acc_reg;

    // decode of the offered item
    logic               in_range;
    logic [15:0]        key_idx_full;
    logic               idx_low;
    logic [16:0]        pair_press_full;
    logic [16:0]        pair_read_full;
    logic               pair_ok;
    logic [KEY_AW-1:0]  key_addr;
    logic [PAIR_AW-1:0] pair_addr;

    always_comb begin
        in_range        = (s_row < 8'(ROWS)) && (s_col < 8'(COLS));
        key_idx_full    = in_range ? (16'(s_row) * 16'(COLS) + 16'(s_col)) : 16'd0;
        idx_low         = key_idx_full < 16'(KEYS);
        key_addr        = key_idx_full[KEY_AW-1:0];
        pair_press_full = 17'(prev_key_reg) * 17'(KEYS) + 17'(key_idx_full);
        pair_read_full  = 17'(s_first_key) * 17'(KEYS) + 17'(s_second_key);
        if (s_operation == OP_PRESS) begin
            pair_ok   = prev_valid_reg && (17'(prev_key_reg) < 17'(KEYS)) && idx_low;
            pair_addr = pair_press_full[PAIR_AW-1:0];
        end else begin
            pair_ok   = (9'(s_first_key) < 9'(KEYS)) && (9'(s_second_key) < 9'(KEYS));
            pair_addr = pair_read_full[PAIR_AW-1:0];
        end
    end

    // capture item and issue store reads
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg        <= s_operation;
            in_range_reg  <= in_range;
            idx_low_reg   <= idx_low;
            pair_ok_reg   <= pair_ok;
            key_addr_reg  <= key_addr;
            pair_addr_reg <= pair_addr;
            key_rd_reg    <= key_mem[key_addr];
            key_hit_reg   <= key_valid_reg[key_addr];
            pair_rd_reg   <= pair_mem[pair_addr];
        end
    end

    // update arithmetic for the item in flight
    logic [31:0] key_cur, key_new;
    logic        counted, pair_inc;
    logic [15:0] pair_new;

    always_comb begin
        key_cur  = key_hit_reg ? key_rd_reg : 32'd0;
        key_new  = sat_inc32(key_cur);
        counted  = (op_reg == OP_PRESS) && in_range_reg && stats_enable_reg;
        pair_inc = counted && pair_ok_reg && (pair_rd_reg != MAX16);
        pair_new = pair_inc ? pair_rd_reg + 16'd1 : pair_rd_reg;
    end

    // next totals, peaks and result fields
    always_comb begin
        presses_sum_next = presses_sum_reg;
        pairs_sum_next   = pairs_sum_reg;
        key_peak_next    = key_peak_reg;
        pair_peak_next   = pair_peak_reg;
        kc_next          = 32'd0;
        pc_next          = 16'd0;
        unique case (op_reg)
            OP_PRESS: begin
                if (counted) begin
                    presses_sum_next = sat_inc32(presses_sum_reg);
                    if (key_new > key_peak_reg) key_peak_next = key_new;
                    if (pair_inc) pairs_sum_next = sat_inc32(pairs_sum_reg);
                    if (pair_ok_reg) begin
                        pc_next = pair_new;
                        if (pair_new > pair_peak_reg) pair_peak_next = pair_new;
                    end
                    kc_next = key_new;
                end else if (in_range_reg) begin
                    kc_next = key_cur;
                end
            end
            OP_READ_KEY: begin
                if (in_range_reg) kc_next = key_cur;
            end
            OP_READ_PAIR: begin
                if (pair_ok_reg) pc_next = pair_rd_reg;
            end
            OP_CLEAR_KEYS: begin
                presses_sum_next = 32'd0;
                key_peak_next    = 32'd0;
            end
            OP_CLEAR_PAIRS: begin
                pairs_sum_next = 32'd0;
                pair_peak_next = 16'd0;
            end
            default: begin
            end
        endcase
    end

    // key store write
    always_ff @(posedge aclk) begin
        if (cmd.exec && counted) key_mem[key_addr_reg] <= key_new;
    end

    // pair store write, shared by the clearing pass and the increment
    always_ff @(posedge aclk) begin
        if (cmd.sweep) begin
            pair_mem[sweep_reg] <= 16'd0;
        end else if (cmd.exec && pair_inc) begin
            pair_mem[pair_addr_reg] <= pair_new;
        end
    end

    // architectural state and clearing-pass counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_valid_reg    <= '0;
            stats_enable_reg <= 1'b1;
            presses_sum_reg  <= 32'd0;
            pairs_sum_reg    <= 32'd0;
            key_peak_reg     <= 32'd0;
            pair_peak_reg    <= 16'd0;
            prev_key_reg     <= '0;
            prev_valid_reg   <= 1'b0;
            sweep_reg        <= '0;
        end else begin
            if (cfg_wr_en) stats_enable_reg <= cfg_wr_data;
            if (cmd.sweep) begin
                sweep_reg <= status.sweep_last ? '0 : sweep_reg + PAIR_AW'(1);
            end
            if (cmd.exec) begin
                presses_sum_reg <= presses_sum_next;
                pairs_sum_reg   <= pairs_sum_next;
                key_peak_reg    <= key_peak_next;
                pair_peak_reg   <= pair_peak_next;
                if (counted) begin
                    key_valid_reg[key_addr_reg] <= 1'b1;
                    prev_key_reg   <= idx_low_reg ? PREV_W'(key_addr_reg) : '0;
                    prev_valid_reg <= idx_low_reg;
                end
                if (op_reg == OP_CLEAR_KEYS) key_valid_reg <= '0;
                if (op_reg == OP_CLEAR_PAIRS) begin
                    prev_key_reg   <= '0;
                    prev_valid_reg <= 1'b0;
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.exec) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            kc_reg  <= kc_next;
            pc_reg  <= pc_next;
            acc_reg <= counted;
        end
    end

    // status to the controller
    assign status.out_free      = !m_valid_reg || m_ready;
    assign status.op_pair_clear = (op_reg == OP_CLEAR_PAIRS);
    assign status.sweep_last    = (sweep_reg == PAIR_AW'(PAIR_DEPTH - 1));

    assign m_valid              = m_valid_reg;
    assign m_key_count          = kc_reg;
    assign m_pair_count         = pc_reg;
    assign m_press_total        = presses_sum_reg;
    assign m_pair_total         = pairs_sum_reg;
    assign m_largest_key_count  = key_peak_reg;
    assign m_largest_pair_count = pair_peak_reg;
    assign m_accepted           = acc_reg;

endmodule

>>> verif/tb_top.sv
// self-checking testbench for the keypress and bigram counter core
`timescale 1ns / 1ps

module tb_top;
    import kbc_pkg::*;

    // codes that the block leaves unused
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // how a script row gets its expected result
    localparam bit TYPED   = 1'b1;
    localparam bit PREDICT = 1'b0;

    localparam int HOT_KEYS    = 6;
    localparam int STALL_LIMIT = 60000;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] first_key;
        logic [7:0] second_key;
    } stim_t;

    typedef struct packed {
        logic [31:0] key_count;
        logic [15:0] pair_count;
        logic [31:0] press_total;
        logic [31:0] pair_total;
        logic [31:0] largest_key;
        logic [15:0] largest_pair;
        logic        accepted;
    } result_t;

    typedef struct {
        bit      stats;
        stim_t   item;
        bit      typed;
        result_t want;
    } script_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_operation = '0;
    logic [7:0]  s_row = '0;
    logic [7:0]  s_col = '0;
    logic [7:0]  s_first_key = '0;
    logic [7:0]  s_second_key = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_key_count;
    logic [15:0] m_pair_count;
    logic [31:0] m_press_total;
    logic [31:0] m_pair_total;
    logic [31:0] m_largest_key_count;
    logic [15:0] m_largest_pair_count;
    logic        m_accepted;

    // predicted state of the block
    logic [31:0] key_tally [KEY_DEPTH];
    logic [15:0] pair_tally [PAIR_DEPTH];
    logic [31:0] press_sum = '0;
    logic [31:0] pair_sum = '0;
    logic [31:0] key_peak = '0;
    logic [15:0] pair_peak = '0;
    int unsigned last_key = 0;
    bit          last_key_valid = 1'b0;
    bit          stats_on = 1'b1;

    result_t     owed_results [$];
    script_row_t script [$];
    int unsigned hot_keys [HOT_KEYS];
    int          fail_count = 0;
    int          tx_gap_pct = 20;
    int          rx_stall_pct = 20;
    int          rx_hold = 0;
    int          idle_cycles = 0;

    keypress_and_bigram_counter_core u_top (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_data          (cfg_wr_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_operation          (s_operation),
        .s_row                (s_row),
        .s_col                (s_col),
        .s_first_key          (s_first_key),
        .s_second_key         (s_second_key),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_key_count          (m_key_count),
        .m_pair_count         (m_pair_count),
        .m_press_total        (m_press_total),
        .m_pair_total         (m_pair_total),
        .m_largest_key_count  (m_largest_key_count),
        .m_largest_pair_count (m_largest_pair_count),
        .m_accepted           (m_accepted)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // counter increment that sticks at all ones
    function automatic logic [31:0] sat_add_one(input logic [31:0] v);
        logic [32:0] sum;
        sum = {1'b0, v} + 33'd1;
        return sum[32] ? v : sum[31:0];
    endfunction

    // apply one item to the predicted state and return its result
    function automatic result_t count_item(input stim_t it);
        result_t     r;
        bit          in_range;
        int unsigned idx;
        int unsigned pidx;
        logic [31:0] bumped;
        r = '0;
        in_range = (it.row < ROWS) && (it.col < COLS);
        idx = in_range ? it.row * COLS + it.col : 0;
        case (it.op)
            OP_PRESS: begin
                if (in_range && stats_on) begin
                    bumped = sat_add_one(key_tally[idx]);
                    key_tally[idx] = bumped;
                    press_sum = sat_add_one(press_sum);
                    if (bumped > key_peak) key_peak = bumped;
                    r.accepted = 1'b1;
                    if (idx < KEYS) begin
                        // pair with the key pressed before, if any
                        if (last_key_valid && last_key < KEYS) begin
                            pidx = last_key * KEYS + idx;
                            if (pair_tally[pidx] != MAX16) begin
                                pair_tally[pidx] = pair_tally[pidx] + 16'd1;
                                pair_sum = sat_add_one(pair_sum);
                            end
                            r.pair_count = pair_tally[pidx];
                            if (pair_tally[pidx] > pair_peak) pair_peak = pair_tally[pidx];
                        end
                        last_key = idx;
                        last_key_valid = 1'b1;
                    end else begin
                        last_key = 0;
                        last_key_valid = 1'b0;
                    end
                end
                if (in_range) r.key_count = key_tally[idx];
            end
            OP_READ_KEY: begin
                if (in_range) r.key_count = key_tally[idx];
            end
            OP_READ_PAIR: begin
                if (it.first_key < KEYS && it.second_key < KEYS)
                    r.pair_count = pair_tally[it.first_key * KEYS + it.second_key];
            end
            OP_CLEAR_KEYS: begin
                foreach (key_tally[i]) key_tally[i] = '0;
                press_sum = '0;
                key_peak = '0;
            end
            OP_CLEAR_PAIRS: begin
                foreach (pair_tally[i]) pair_tally[i] = '0;
                pair_sum = '0;
                pair_peak = '0;
                last_key = 0;
                last_key_valid = 1'b0;
            end
            default: ;
        endcase
        r.press_total = press_sum;
        r.pair_total = pair_sum;
        r.largest_key = key_peak;
        r.largest_pair = pair_peak;
        return r;
    endfunction

    function automatic string fmt_result(input result_t r);
        return $sformatf("key=%0d pair=%0d presses=%0d pairs=%0d max_key=%0d max_pair=%0d acc=%0d",
                         r.key_count, r.pair_count, r.press_total, r.pair_total,
                         r.largest_key, r.largest_pair, r.accepted);
    endfunction

    // idle stretch: mostly short, now and then long
    function automatic int idle_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(5, 40);
    endfunction

    // random item, biased toward a few hot keys so pairs repeat
    function automatic stim_t random_item();
        stim_t       it;
        int unsigned pick;
        int unsigned where;
        int unsigned k;
        it.row = 8'($urandom);
        it.col = 8'($urandom);
        it.first_key = 8'($urandom);
        it.second_key = 8'($urandom);
        pick = $urandom_range(0, 999);
        if (pick < 600) it.op = OP_PRESS;
        else if (pick < 750) it.op = OP_READ_KEY;
        else if (pick < 930) it.op = OP_READ_PAIR;
        else if (pick < 950) it.op = OP_CLEAR_KEYS;
        else if (pick < 956) it.op = OP_CLEAR_PAIRS;
        else it.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        where = $urandom_range(0, 99);
        if (where < 65) k = hot_keys[$urandom_range(0, HOT_KEYS - 1)];
        else k = $urandom_range(0, KEY_DEPTH - 1);
        if (where < 90) begin
            it.row = 8'(k / COLS);
            it.col = 8'(k % COLS);
        end
        if (where < 60) begin
            it.first_key = 8'(hot_keys[$urandom_range(0, HOT_KEYS - 1)]);
            it.second_key = 8'(hot_keys[$urandom_range(0, HOT_KEYS - 1)]);
        end else if (where < 85) begin
            it.first_key = 8'($urandom_range(0, KEYS - 1));
            it.second_key = 8'($urandom_range(0, KEYS - 1));
        end
        return it;
    endfunction

    task automatic add_step(input bit stats, input logic [2:0] op, input logic [7:0] row,
                            input logic [7:0] col, input logic [7:0] first_key,
                            input logic [7:0] second_key, input bit typed, input result_t want);
        script_row_t s;
        s.stats = stats;
        s.item = '{op: op, row: row, col: col, first_key: first_key, second_key: second_key};
        s.typed = typed;
        s.want = want;
        script.push_back(s);
    endtask

    // present one item, hold it until taken, then record what it should produce
    task automatic send_item(input stim_t it, input bit typed, input result_t want);
        int      gap;
        result_t predicted;
        gap = ($urandom_range(0, 99) < tx_gap_pct) ? idle_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= it.op;
        s_row <= it.row;
        s_col <= it.col;
        s_first_key <= it.first_key;
        s_second_key <= it.second_key;
        do @(posedge aclk); while (!s_ready);
        predicted = count_item(it);
        owed_results.push_back(typed ? want : predicted);
    endtask

    // stop sending and wait for every owed result
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (owed_results.size() != 0);
    endtask

    task automatic set_stats(input bit value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        stats_on = value;
    endtask

    task automatic run_random(input int count);
        int    sent;
        stim_t it;
        sent = 0;
        while (sent < count) begin
            // change idling every hundred items, including stretches with none
            if (sent % 100 == 0) begin
                tx_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
                rx_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
            end
            if ($urandom_range(0, 99) == 0) settle();
            it = random_item();
            send_item(it, PREDICT, '0);
            sent++;
        end
    endtask

    // result side: random stalls
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else if ($urandom_range(0, 99) < rx_stall_pct) begin
            m_ready <= 1'b0;
            rx_hold = idle_len() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each result with the oldest owed one
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_key_count, m_pair_count, m_press_total, m_pair_total,
                   m_largest_key_count, m_largest_pair_count, m_accepted};
            if (owed_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("%0t unexpected result: %s", $time, fmt_result(got));
            end else begin
                want = owed_results.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("%0t result mismatch", $time);
                        $display("  expected %s", fmt_result(want));
                        $display("  actual   %s", fmt_result(got));
                    end
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        foreach (key_tally[i]) key_tally[i] = '0;
        foreach (pair_tally[i]) pair_tally[i] = '0;

        // directed script: typed results where obvious, the rest predicted
        add_step(1, OP_READ_KEY, 0, 0, 0, 0, TYPED, '0);
        add_step(1, OP_SPARE_LO, 0, 0, 0, 0, TYPED, '0);
        add_step(1, OP_READ_PAIR, 0, 0, 0, 0, TYPED, '0);
        add_step(1, OP_PRESS, 0, 0, 0, 0, TYPED,
                 {32'd1, 16'd0, 32'd1, 32'd0, 32'd1, 16'd0, 1'b1});
        add_step(1, OP_PRESS, 7, 15, 8'h5a, 8'ha5, PREDICT, '0);
        add_step(1, OP_PRESS, 8, 0, 0, 0, PREDICT, '0);
        add_step(1, OP_PRESS, 0, 16, 0, 0, PREDICT, '0);
        add_step(1, OP_PRESS, 255, 255, 255, 255, PREDICT, '0);
        add_step(1, OP_PRESS, 7, 15, 0, 0, PREDICT, '0);
        add_step(1, OP_READ_KEY, 7, 15, 0, 0, PREDICT, '0);
        add_step(1, OP_READ_KEY, 255, 255, 0, 0, PREDICT, '0);
        add_step(1, OP_READ_PAIR, 0, 0, 0, 127, PREDICT, '0);
        add_step(1, OP_READ_PAIR, 0, 0, 127, 127, PREDICT, '0);
        add_step(1, OP_READ_PAIR, 0, 0, 128, 0, PREDICT, '0);
        add_step(1, OP_READ_PAIR, 0, 0, 0, 255, PREDICT, '0);
        add_step(1, OP_SPARE_HI, 255, 255, 255, 255, PREDICT, '0);
        add_step(1, OP_CLEAR_KEYS, 0, 0, 0, 0, PREDICT, '0);
        add_step(1, OP_READ_KEY, 7, 15, 0, 0, PREDICT, '0);
        add_step(1, OP_PRESS, 3, 5, 0, 0, PREDICT, '0);
        add_step(1, OP_CLEAR_PAIRS, 0, 0, 0, 0, PREDICT, '0);
        add_step(1, OP_PRESS, 3, 5, 0, 0, PREDICT, '0);
        add_step(1, OP_READ_PAIR, 0, 0, 127, 53, PREDICT, '0);
        // counting switched off
        add_step(0, OP_PRESS, 3, 5, 0, 0, PREDICT, '0);
        add_step(0, OP_PRESS, 2, 2, 0, 0, PREDICT, '0);
        add_step(0, OP_READ_KEY, 3, 5, 0, 0, PREDICT, '0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_stats(1'b1);

        // walk the directed script
        tx_gap_pct = 30;
        rx_stall_pct = 30;
        foreach (script[i]) begin
            if (script[i].stats != stats_on) begin
                settle();
                set_stats(script[i].stats);
            end
            send_item(script[i].item, script[i].typed, script[i].want);
        end
        settle();
        set_stats(1'b1);

        // random phases across both enable settings
        foreach (hot_keys[i]) hot_keys[i] = $urandom_range(0, KEY_DEPTH - 1);
        run_random(650);
        settle();
        set_stats(1'b0);
        run_random(200);
        settle();
        set_stats(1'b1);
        run_random(475);

        settle();
        repeat (20) @(posedge aclk);
        if (owed_results.size() != 0) fail_count += owed_results.size();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
